// ===== hdl/vrt_pkg.sv =====
`timescale 1ns / 1ps

package vrt_pkg;

  // Field widths
  localparam int LOC_W   = 21;
  localparam int SP_W    = 29;
  localparam int TP_W    = 40;
  localparam int CODE_W  = 6;
  localparam int GRID_W  = 32;

  // Fixed-point scale: units per voxel is a power of two
  localparam int UPV_LOG2        = 8;
  localparam int UNITS_PER_VOXEL = 1 << UPV_LOG2;

  // Datapath widths
  localparam int D_W   = SP_W + 1;               // scaled local minus source pivot
  localparam int R_W   = D_W + 1;                // after mirror / rotation
  localparam int SUM_W = TP_W + 2;               // target pivot + rotated + half
  localparam int Q_W   = SUM_W - UPV_LOG2;       // grid value before range check

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CODE = 3'd0,
    REG_SP_X = 3'd1,
    REG_SP_Y = 3'd2,
    REG_SP_Z = 3'd3,
    REG_TP_X = 3'd4,
    REG_TP_Y = 3'd5,
    REG_TP_Z = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INEXACT  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_BAD_AXIS = 2'd3
  } status_e;

  typedef logic signed [D_W-1:0]   d_t;
  typedef logic signed [R_W-1:0]   r_t;
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

// ===== hdl/voxel_rigid_transform.sv =====
`timescale 1ns / 1ps

// voxel_rigid_transform: maps one integer local voxel position (local_x/y/z)
// to a world grid position. Each position is scaled to fixed point
// (UNITS_PER_VOXEL = 256 units per voxel), the source pivot is subtracted,
// X and/or Z are mirrored, 0..3 quarter turns are applied about the selected
// axis and the target pivot is added; the sum is then brought back to whole
// voxels. An even turn count needs an exact multiple (else status 1), an odd
// one rounds half up. A grid value outside 32-bit signed gives status 2, axis
// code 3 gives status 3; on any failure world_x/y/z are zero.
// Rate: one position per clock, sustained while the output accepts. Four register stages
// (pivot subtract, mirror/rotate, pivot add, grid check into the output
// register) lie between input transaction and result.
// Backpressure is combinational through all stages; empty stages keep filling while the
// output waits. Registers sit on the APB-style port at byte address 8*index:
// 0 transform_code, 8/16/24 source pivot X/Y/Z, 32/40/48 target pivot X/Y/Z.
// Write them only while no transaction is in flight.
module voxel_rigid_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [20:0] local_x, [41:21] local_y, [62:42] local_z
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] world_x, [63:32] world_y, [95:64] world_z
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vrt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vrt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                        pready
);

  import vrt_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0]      code_q;
  logic signed [SP_W-1:0] sp_q [3];
  logic signed [TP_W-1:0] tp_q [3];

  reg_e  cfg_idx;
  logic  cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      for (int i = 0; i < 3; i++) begin
        sp_q[i] <= '0;
        tp_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CODE: code_q  <= pwdata[CODE_W-1:0];
        REG_SP_X: sp_q[0] <= pwdata[SP_W-1:0];
        REG_SP_Y: sp_q[1] <= pwdata[SP_W-1:0];
        REG_SP_Z: sp_q[2] <= pwdata[SP_W-1:0];
        REG_TP_X: tp_q[0] <= pwdata[TP_W-1:0];
        REG_TP_Y: tp_q[1] <= pwdata[TP_W-1:0];
        REG_TP_Z: tp_q[2] <= pwdata[TP_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_CODE: prdata = CFG_DATA_W'(code_q);
      REG_SP_X: prdata = CFG_DATA_W'(sp_q[0]);
      REG_SP_Y: prdata = CFG_DATA_W'(sp_q[1]);
      REG_SP_Z: prdata = CFG_DATA_W'(sp_q[2]);
      REG_TP_X: prdata = CFG_DATA_W'(tp_q[0]);
      REG_TP_Y: prdata = CFG_DATA_W'(tp_q[1]);
      REG_TP_Z: prdata = CFG_DATA_W'(tp_q[2]);
      default:  prdata = '0;
    endcase
  end

  logic [1:0] mirror;
  axis_e      axis;
  logic [1:0] turns;

  assign mirror = code_q[1:0];
  assign axis   = axis_e'(code_q[3:2]);
  assign turns  = code_q[5:4];

  // ---------------------------------------------------------------------------
  // Pipeline handshake: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = ~v4_q | m_axis_tready;
  assign rdy3 = ~v3_q | rdy4;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: scale to fixed point, subtract source pivot
  // ---------------------------------------------------------------------------
  logic [LOC_W-1:0] loc [3];
  d_t               d1_d [3];
  d_t               d1_q [3];

  assign loc[0] = s_axis_tdata[LOC_W-1:0];
  assign loc[1] = s_axis_tdata[2*LOC_W-1:LOC_W];
  assign loc[2] = s_axis_tdata[3*LOC_W-1:2*LOC_W];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = d_t'({{(D_W-LOC_W-UPV_LOG2){loc[i][LOC_W-1]}}, loc[i], {UPV_LOG2{1'b0}}})
              - d_t'({{(D_W-SP_W){sp_q[i][SP_W-1]}}, sp_q[i]});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: mirror, then quarter turns in closed form
  // ---------------------------------------------------------------------------
  r_t   m2 [3];
  r_t   r2_d [3];
  r_t   r2_q [3];
  logic odd2_q, bad2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2[i] = r_t'({d1_q[i][D_W-1], d1_q[i]});
    end
    if (mirror[0]) m2[0] = -m2[0];
    if (mirror[1]) m2[2] = -m2[2];

    for (int i = 0; i < 3; i++) begin
      r2_d[i] = m2[i];
    end
    case (axis)
      AXIS_X: begin  // (y,z) -> (-z,y)
        case (turns)
          2'd1: begin r2_d[1] = -m2[2]; r2_d[2] =  m2[1]; end
          2'd2: begin r2_d[1] = -m2[1]; r2_d[2] = -m2[2]; end
          2'd3: begin r2_d[1] =  m2[2]; r2_d[2] = -m2[1]; end
          default: ;
        endcase
      end
      AXIS_Y: begin  // (x,z) -> (z,-x)
        case (turns)
          2'd1: begin r2_d[0] =  m2[2]; r2_d[2] = -m2[0]; end
          2'd2: begin r2_d[0] = -m2[0]; r2_d[2] = -m2[2]; end
          2'd3: begin r2_d[0] = -m2[2]; r2_d[2] =  m2[0]; end
          default: ;
        endcase
      end
      AXIS_Z: begin  // (x,y) -> (-y,x)
        case (turns)
          2'd1: begin r2_d[0] = -m2[1]; r2_d[1] =  m2[0]; end
          2'd2: begin r2_d[0] = -m2[0]; r2_d[1] = -m2[1]; end
          2'd3: begin r2_d[0] =  m2[1]; r2_d[1] = -m2[0]; end
          default: ;
        endcase
      end
      default: ;  // invalid axis, flagged below
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add target pivot, plus half a voxel when rounding
  // ---------------------------------------------------------------------------
  localparam sum_t HALF = sum_t'(UNITS_PER_VOXEL / 2);

  sum_t s3_d [3];
  sum_t s3_q [3];
  logic odd3_q, bad3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_d[i] = sum_t'({{(SUM_W-TP_W){tp_q[i][TP_W-1]}}, tp_q[i]})
              + sum_t'({{(SUM_W-R_W){r2_q[i][R_W-1]}}, r2_q[i]})
              + (odd2_q ? HALF : '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: exactness and range check; a bad axis first, else the first failing coordinate wins
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0]    q4 [3];
  status_e           cst [3];
  status_e           st4_d;
  logic [GRID_W-1:0] w4_d [3];
  logic [GRID_W-1:0] w4_q [3];
  status_e           st4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q4[i] = s3_q[i][SUM_W-1:UPV_LOG2];  // floor division by units per voxel
      if (!odd3_q && (s3_q[i][UPV_LOG2-1:0] != '0)) begin
        cst[i] = ST_INEXACT;
      end else if (!((&q4[i][Q_W-1:GRID_W-1]) || !(|q4[i][Q_W-1:GRID_W-1]))) begin
        cst[i] = ST_RANGE;
      end else begin
        cst[i] = ST_OK;
      end
    end

    if (bad3_q)                st4_d = ST_BAD_AXIS;
    else if (cst[0] != ST_OK)  st4_d = cst[0];
    else if (cst[1] != ST_OK)  st4_d = cst[1];
    else                       st4_d = cst[2];

    for (int i = 0; i < 3; i++) begin
      w4_d[i] = (st4_d == ST_OK) ? q4[i][GRID_W-1:0] : '0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy1) begin
      d1_q <= d1_d;
    end
    if (v1_q && rdy2) begin
      r2_q   <= r2_d;
      odd2_q <= turns[0];
      bad2_q <= (axis == AXIS_NONE);
    end
    if (v2_q && rdy3) begin
      s3_q   <= s3_d;
      odd3_q <= odd2_q;
      bad3_q <= bad2_q;
    end
    if (v3_q && rdy4) begin
      w4_q  <= w4_d;
      st4_q <= st4_d;
    end
  end

  assign m_axis_tdata = {w4_q[2], w4_q[1], w4_q[0]};
  assign m_axis_tuser = st4_q;

endmodule
